### rtl/rcf_pkg.sv
// Package with the shared types, weights and helpers of the RGB color filter.
`timescale 1ns / 1ps

package rcf_pkg;

  localparam int CHAN_W  = 8;
  localparam int PIXEL_W = 3 * CHAN_W;
  localparam int WEIGHT_W = 10;
  // Largest weighted sum is 1351 * 255 = 344505, which fits in 19 bits.
  localparam int SUM_W = 19;

  // floor(s / 1000) = (s * 134218) >> 27 holds exactly for every s up to 493447,
  // which covers the largest weighted sum.
  localparam int RECIP_W = 18;
  localparam logic [RECIP_W-1:0] RECIP_MULT = 18'd134218;
  localparam int PROD_W = SUM_W + RECIP_W;
  localparam int DIV_SHIFT = 27;
  localparam int QUOT_W = PROD_W - DIV_SHIFT;

  localparam logic [CHAN_W-1:0] CHAN_MAX = 8'hFF;
  localparam logic [CHAN_W-1:0] POSTER_MASK = 8'hC0;

  typedef enum logic [2:0] {
    MODE_ORIGINAL  = 3'd0,
    MODE_GRAY      = 3'd1,
    MODE_SEPIA     = 3'd2,
    MODE_INVERT    = 3'd3,
    MODE_POSTERIZE = 3'd4
  } mode_t;

  // Weights in exact thousandths.
  localparam logic [WEIGHT_W-1:0] GRAY_WR = 10'd300;
  localparam logic [WEIGHT_W-1:0] GRAY_WG = 10'd590;
  localparam logic [WEIGHT_W-1:0] GRAY_WB = 10'd110;

  localparam logic [WEIGHT_W-1:0] SEPIA_R_WR = 10'd393;
  localparam logic [WEIGHT_W-1:0] SEPIA_R_WG = 10'd769;
  localparam logic [WEIGHT_W-1:0] SEPIA_R_WB = 10'd189;
  localparam logic [WEIGHT_W-1:0] SEPIA_G_WR = 10'd349;
  localparam logic [WEIGHT_W-1:0] SEPIA_G_WG = 10'd686;
  localparam logic [WEIGHT_W-1:0] SEPIA_G_WB = 10'd168;
  localparam logic [WEIGHT_W-1:0] SEPIA_B_WR = 10'd272;
  localparam logic [WEIGHT_W-1:0] SEPIA_B_WG = 10'd534;
  localparam logic [WEIGHT_W-1:0] SEPIA_B_WB = 10'd131;

  // Weighted sum of three channels by constant weights.
  function automatic logic [SUM_W-1:0] weigh_sum(
    input logic [CHAN_W-1:0]   r,
    input logic [CHAN_W-1:0]   g,
    input logic [CHAN_W-1:0]   b,
    input logic [WEIGHT_W-1:0] wr,
    input logic [WEIGHT_W-1:0] wg,
    input logic [WEIGHT_W-1:0] wb
  );
    logic [SUM_W-1:0] acc;
    acc = SUM_W'(wr) * SUM_W'(r) + SUM_W'(wg) * SUM_W'(g) + SUM_W'(wb) * SUM_W'(b);
    return acc;
  endfunction

endpackage

### rtl/rcf_sum_stage.sv
// Weighted-sum stage: forms the three per-channel sums and registers them.
`timescale 1ns / 1ps

module rcf_sum_stage (
  input  logic                                        clk,
  input  logic                                        load,
  input  logic [rcf_pkg::PIXEL_W-1:0]                 pixel,
  input  rcf_pkg::mode_t                              mode,
  output logic [rcf_pkg::SUM_W-1:0]                   sum_r,
  output logic [rcf_pkg::SUM_W-1:0]                   sum_g,
  output logic [rcf_pkg::SUM_W-1:0]                   sum_b,
  output logic [rcf_pkg::PIXEL_W-1:0]                 pixel_q,
  output rcf_pkg::mode_t                              mode_q
);

  logic [rcf_pkg::CHAN_W-1:0] r;
  logic [rcf_pkg::CHAN_W-1:0] g;
  logic [rcf_pkg::CHAN_W-1:0] b;
  logic [rcf_pkg::SUM_W-1:0]  gray_sum;
  logic [rcf_pkg::SUM_W-1:0]  sepia_r_sum;
  logic [rcf_pkg::SUM_W-1:0]  sum_r_next;
  logic [rcf_pkg::SUM_W-1:0]  sum_g_next;
  logic [rcf_pkg::SUM_W-1:0]  sum_b_next;

  assign r = pixel[23:16];
  assign g = pixel[15:8];
  assign b = pixel[7:0];

  assign gray_sum = rcf_pkg::weigh_sum(r, g, b, rcf_pkg::GRAY_WR, rcf_pkg::GRAY_WG,
                                       rcf_pkg::GRAY_WB);
  assign sepia_r_sum = rcf_pkg::weigh_sum(r, g, b, rcf_pkg::SEPIA_R_WR,
                                          rcf_pkg::SEPIA_R_WG, rcf_pkg::SEPIA_R_WB);

  // Grayscale puts the same gray sum on all three channels; other modes form the sepia sums.
  always_comb begin
    if (mode == rcf_pkg::MODE_GRAY) begin
      sum_r_next = gray_sum;
      sum_g_next = gray_sum;
      sum_b_next = gray_sum;
    end else begin
      sum_r_next = sepia_r_sum;
      sum_g_next = rcf_pkg::weigh_sum(r, g, b, rcf_pkg::SEPIA_G_WR,
                                      rcf_pkg::SEPIA_G_WG, rcf_pkg::SEPIA_G_WB);
      sum_b_next = rcf_pkg::weigh_sum(r, g, b, rcf_pkg::SEPIA_B_WR,
                                      rcf_pkg::SEPIA_B_WG, rcf_pkg::SEPIA_B_WB);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      sum_r   <= sum_r_next;
      sum_g   <= sum_g_next;
      sum_b   <= sum_b_next;
      pixel_q <= pixel;
      mode_q  <= mode;
    end
  end

endmodule

### rtl/rcf_out_stage.sv
// Output stage: divides the sums by 1000, clamps, applies the mode and registers the pixel.
`timescale 1ns / 1ps

module rcf_out_stage (
  input  logic                              clk,
  input  logic                              load,
  input  logic [rcf_pkg::SUM_W-1:0]         sum_r,
  input  logic [rcf_pkg::SUM_W-1:0]         sum_g,
  input  logic [rcf_pkg::SUM_W-1:0]         sum_b,
  input  logic [rcf_pkg::PIXEL_W-1:0]       pixel,
  input  rcf_pkg::mode_t                    mode,
  output logic [rcf_pkg::PIXEL_W-1:0]       pixel_out
);

  logic [rcf_pkg::PROD_W-1:0]  prod_r;
  logic [rcf_pkg::PROD_W-1:0]  prod_g;
  logic [rcf_pkg::PROD_W-1:0]  prod_b;
  logic [rcf_pkg::QUOT_W-1:0]  quot_r;
  logic [rcf_pkg::QUOT_W-1:0]  quot_g;
  logic [rcf_pkg::QUOT_W-1:0]  quot_b;
  logic [rcf_pkg::CHAN_W-1:0]  div_r;
  logic [rcf_pkg::CHAN_W-1:0]  div_g;
  logic [rcf_pkg::CHAN_W-1:0]  div_b;
  logic [rcf_pkg::CHAN_W-1:0]  r;
  logic [rcf_pkg::CHAN_W-1:0]  g;
  logic [rcf_pkg::CHAN_W-1:0]  b;
  logic [rcf_pkg::PIXEL_W-1:0] pixel_out_next;

  assign r = pixel[23:16];
  assign g = pixel[15:8];
  assign b = pixel[7:0];

  // Division by 1000 as a multiply by a scaled reciprocal.
  assign prod_r = rcf_pkg::PROD_W'(sum_r) * rcf_pkg::PROD_W'(rcf_pkg::RECIP_MULT);
  assign prod_g = rcf_pkg::PROD_W'(sum_g) * rcf_pkg::PROD_W'(rcf_pkg::RECIP_MULT);
  assign prod_b = rcf_pkg::PROD_W'(sum_b) * rcf_pkg::PROD_W'(rcf_pkg::RECIP_MULT);

  assign quot_r = prod_r[rcf_pkg::PROD_W-1 -: rcf_pkg::QUOT_W];
  assign quot_g = prod_g[rcf_pkg::PROD_W-1 -: rcf_pkg::QUOT_W];
  assign quot_b = prod_b[rcf_pkg::PROD_W-1 -: rcf_pkg::QUOT_W];

  assign div_r = (quot_r > rcf_pkg::QUOT_W'(rcf_pkg::CHAN_MAX)) ? rcf_pkg::CHAN_MAX
                                                                : quot_r[7:0];
  assign div_g = (quot_g > rcf_pkg::QUOT_W'(rcf_pkg::CHAN_MAX)) ? rcf_pkg::CHAN_MAX
                                                                : quot_g[7:0];
  assign div_b = (quot_b > rcf_pkg::QUOT_W'(rcf_pkg::CHAN_MAX)) ? rcf_pkg::CHAN_MAX
                                                                : quot_b[7:0];

  always_comb begin
    unique case (mode)
      rcf_pkg::MODE_GRAY, rcf_pkg::MODE_SEPIA: begin
        pixel_out_next = {div_r, div_g, div_b};
      end
      rcf_pkg::MODE_INVERT: begin
        pixel_out_next = {rcf_pkg::CHAN_MAX - r, rcf_pkg::CHAN_MAX - g,
                          rcf_pkg::CHAN_MAX - b};
      end
      rcf_pkg::MODE_POSTERIZE: begin
        pixel_out_next = {r & rcf_pkg::POSTER_MASK, g & rcf_pkg::POSTER_MASK,
                          b & rcf_pkg::POSTER_MASK};
      end
      default: begin
        // Original mode and the unused codes pass the pixel through.
        pixel_out_next = pixel;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (load) begin
      pixel_out <= pixel_out_next;
    end
  end

endmodule

### rtl/rgb_color_filter_unit.sv
// Top level of the RGB color filter: handshake, mode register and the three-stage pipeline.
`timescale 1ns / 1ps

// Filters a stream of packed 24-bit RGB pixels (red 23:16, green 15:8, blue 7:0) by the
// mode in filter_mode: 0 original, 1 grayscale, 2 sepia, 3 invert, 4 posterize; codes 5
// to 7 pass the pixel through. The block takes one pixel per clock while in_stall is low
// and presents each result on pixel_out through three registers: the input register
// loads at the transfer edge, then the weighted-sum register and the output register
// follow; a stall at the output holds the pipeline, and its three stages absorb bubbles
// so a new pixel is taken while a finished one waits.
// The mode is captured with each pixel at its transfer.
module rgb_color_filter_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          filter_mode_wr_en,
  input  logic [2:0]                    filter_mode,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [rcf_pkg::PIXEL_W-1:0]   pixel_in,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [rcf_pkg::PIXEL_W-1:0]   pixel_out
);

  rcf_pkg::mode_t              mode_reg;
  logic                        in_reg_valid;
  logic                        sum_valid;
  logic                        in_reg_valid_next;
  logic                        sum_valid_next;
  logic                        out_valid_next;
  logic [rcf_pkg::PIXEL_W-1:0] in_pixel;
  rcf_pkg::mode_t              in_mode;
  logic                        out_ready;
  logic                        sum_ready;
  logic                        in_ready;
  logic                        in_xfer;
  logic                        sum_load;
  logic                        out_load;
  logic [rcf_pkg::SUM_W-1:0]   sum_r;
  logic [rcf_pkg::SUM_W-1:0]   sum_g;
  logic [rcf_pkg::SUM_W-1:0]   sum_b;
  logic [rcf_pkg::PIXEL_W-1:0] sum_pixel;
  rcf_pkg::mode_t              sum_mode;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode_reg <= rcf_pkg::MODE_ORIGINAL;
    end else if (filter_mode_wr_en) begin
      mode_reg <= rcf_pkg::mode_t'(filter_mode);
    end
  end

  // Each stage moves on when it is empty or the stage after it can take its contents.
  assign out_ready = !out_valid || !out_stall;
  assign sum_ready = !sum_valid || out_ready;
  assign in_ready  = !in_reg_valid || sum_ready;
  assign in_stall  = !in_ready;

  assign in_xfer  = in_valid && in_ready;
  assign sum_load = in_reg_valid && sum_ready;
  assign out_load = sum_valid && out_ready;

  assign in_reg_valid_next = in_xfer || (in_reg_valid && !sum_ready);
  assign sum_valid_next    = sum_load || (sum_valid && !out_ready);
  assign out_valid_next    = out_load || (out_valid && out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      in_reg_valid <= 1'b0;
      sum_valid    <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      in_reg_valid <= in_reg_valid_next;
      sum_valid    <= sum_valid_next;
      out_valid    <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      in_pixel <= pixel_in;
      in_mode  <= mode_reg;
    end
  end

  rcf_sum_stage u_sum (
    .clk     (clk),
    .load    (sum_load),
    .pixel   (in_pixel),
    .mode    (in_mode),
    .sum_r   (sum_r),
    .sum_g   (sum_g),
    .sum_b   (sum_b),
    .pixel_q (sum_pixel),
    .mode_q  (sum_mode)
  );

  rcf_out_stage u_out (
    .clk       (clk),
    .load      (out_load),
    .sum_r     (sum_r),
    .sum_g     (sum_g),
    .sum_b     (sum_b),
    .pixel     (sum_pixel),
    .mode      (sum_mode),
    .pixel_out (pixel_out)
  );

endmodule

### tb/rgb_color_filter_unit_tb.sv
// Self-checking testbench for the RGB color filter with random flow control.
`timescale 1ns / 1ps

module rgb_color_filter_unit_tb;

  localparam int CYCLE_LIMIT = 200000;
  localparam int PIPE_DEPTH = 3;
  localparam int LONG_HOLD_AT = 200;
  localparam int LONG_HOLD_CYCLES = 150;

  // Mode codes that the block treats as pass-through.
  localparam logic [2:0] MODE_RSVD5 = 3'd5;
  localparam logic [2:0] MODE_RSVD6 = 3'd6;
  localparam logic [2:0] MODE_RSVD7 = 3'd7;

  localparam int unsigned LUMA_R = 300;
  localparam int unsigned LUMA_G = 590;
  localparam int unsigned LUMA_B = 110;
  localparam int unsigned SEP_RR = 393;
  localparam int unsigned SEP_RG = 769;
  localparam int unsigned SEP_RB = 189;
  localparam int unsigned SEP_GR = 349;
  localparam int unsigned SEP_GG = 686;
  localparam int unsigned SEP_GB = 168;
  localparam int unsigned SEP_BR = 272;
  localparam int unsigned SEP_BG = 534;
  localparam int unsigned SEP_BB = 131;

  typedef enum logic [1:0] {
    STEP_PIXEL,
    STEP_MODE,
    STEP_DRAIN
  } step_kind_t;

  typedef struct {
    step_kind_t                  kind;
    logic [rcf_pkg::PIXEL_W-1:0] data;
    int unsigned                 gap;
  } step_t;

  logic                        clk = 1'b0;
  logic                        rst = 1'b1;
  logic                        filter_mode_wr_en = 1'b0;
  logic [2:0]                  filter_mode = '0;
  logic                        in_valid = 1'b0;
  logic                        in_stall;
  logic [rcf_pkg::PIXEL_W-1:0] pixel_in = '0;
  logic                        out_valid;
  logic                        out_stall = 1'b0;
  logic [rcf_pkg::PIXEL_W-1:0] pixel_out;

  step_t                       stim_q[$];
  logic [rcf_pkg::PIXEL_W-1:0] filtered_q[$];
  logic [2:0]                  mode_shadow = rcf_pkg::MODE_ORIGINAL;
  int unsigned                 err_cnt = 0;
  int unsigned                 cycle_cnt = 0;

  rgb_color_filter_unit dut (
    .clk               (clk),
    .rst               (rst),
    .filter_mode_wr_en (filter_mode_wr_en),
    .filter_mode       (filter_mode),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .pixel_in          (pixel_in),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .pixel_out         (pixel_out)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic logic [7:0] mix_channel(input logic [7:0] r, input logic [7:0] g,
                                             input logic [7:0] b, input int unsigned wr,
                                             input int unsigned wg, input int unsigned wb);
    int unsigned acc;
    acc = (wr * r + wg * g + wb * b) / 1000;
    return (acc > 255) ? 8'hFF : acc[7:0];
  endfunction

  function automatic logic [rcf_pkg::PIXEL_W-1:0] filter_pixel(
    input logic [2:0] mode,
    input logic [rcf_pkg::PIXEL_W-1:0] px
  );
    logic [7:0] r, g, b, nr, ng, nb;
    r = px[23:16];
    g = px[15:8];
    b = px[7:0];
    nr = r;
    ng = g;
    nb = b;
    case (mode)
      rcf_pkg::MODE_GRAY: begin
        nr = mix_channel(r, g, b, LUMA_R, LUMA_G, LUMA_B);
        ng = nr;
        nb = nr;
      end
      rcf_pkg::MODE_SEPIA: begin
        nr = mix_channel(r, g, b, SEP_RR, SEP_RG, SEP_RB);
        ng = mix_channel(r, g, b, SEP_GR, SEP_GG, SEP_GB);
        nb = mix_channel(r, g, b, SEP_BR, SEP_BG, SEP_BB);
      end
      rcf_pkg::MODE_INVERT: begin
        nr = 8'hFF - r;
        ng = 8'hFF - g;
        nb = 8'hFF - b;
      end
      rcf_pkg::MODE_POSTERIZE: begin
        nr = r & 8'hC0;
        ng = g & 8'hC0;
        nb = b & 8'hC0;
      end
      default: begin
      end
    endcase
    return {nr, ng, nb};
  endfunction

  task automatic add_pixel(input logic [rcf_pkg::PIXEL_W-1:0] px, input int unsigned gap);
    step_t s;
    s.kind = STEP_PIXEL;
    s.data = px;
    s.gap = gap;
    stim_q.push_back(s);
  endtask

  task automatic add_step(input step_kind_t kind, input logic [2:0] mode);
    step_t s;
    s.kind = kind;
    s.data = {{(rcf_pkg::PIXEL_W-3){1'b0}}, mode};
    s.gap = 0;
    stim_q.push_back(s);
  endtask

  function automatic logic [7:0] pick_channel();
    int unsigned sel;
    sel = $urandom_range(0, 3);
    case (sel)
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  // Driver: works through the step queue. Mode writes and drains wait until no
  // transfer is in flight and every filtered pixel has come back.
  always @(posedge clk) begin
    logic        nxt_valid;
    logic        nxt_wr;
    int unsigned gap_left;
    if (rst) begin
      in_valid <= 1'b0;
      filter_mode_wr_en <= 1'b0;
      gap_left = 0;
    end else begin
      nxt_valid = in_valid;
      nxt_wr = 1'b0;
      if (in_valid && !in_stall) nxt_valid = 1'b0;
      if (!nxt_valid && stim_q.size() != 0) begin
        case (stim_q[0].kind)
          STEP_PIXEL: begin
            if (gap_left < stim_q[0].gap) begin
              gap_left++;
            end else begin
              pixel_in <= stim_q[0].data;
              nxt_valid = 1'b1;
              gap_left = 0;
              void'(stim_q.pop_front());
            end
          end
          STEP_MODE: begin
            if (!in_valid && filtered_q.size() == 0) begin
              filter_mode <= stim_q[0].data[2:0];
              mode_shadow = stim_q[0].data[2:0];
              nxt_wr = 1'b1;
              void'(stim_q.pop_front());
            end
          end
          default: begin
            if (!in_valid && filtered_q.size() == 0) void'(stim_q.pop_front());
          end
        endcase
      end
      in_valid <= nxt_valid;
      filter_mode_wr_en <= nxt_wr;
    end
  end

  // Receiver: random stall per result, quiet stretches, and one long hold-off
  // that backs the pipeline up into the input.
  always @(posedge clk) begin
    int unsigned stall_left;
    int unsigned recv_cnt;
    if (rst) begin
      out_stall <= 1'b0;
      stall_left = 0;
      recv_cnt = 0;
    end else begin
      if (out_valid && !out_stall) begin
        recv_cnt++;
        if (recv_cnt == LONG_HOLD_AT) stall_left = LONG_HOLD_CYCLES;
        else if ((recv_cnt / 90) % 3 == 1) stall_left = 0;
        else stall_left = $urandom_range(0, 6);
      end else if (stall_left != 0) begin
        stall_left--;
      end
      out_stall <= (stall_left != 0);
    end
  end

  // Monitor: predict at each input transfer, compare at each output transfer.
  always @(posedge clk) begin
    logic [rcf_pkg::PIXEL_W-1:0] want;
    if (!rst) begin
      if (in_valid && !in_stall) filtered_q.push_back(filter_pixel(mode_shadow, pixel_in));
      if (out_valid && !out_stall) begin
        if (filtered_q.size() == 0) begin
          $error("pixel_out transfer with nothing pending: actual %06h", pixel_out);
          err_cnt++;
        end else begin
          want = filtered_q.pop_front();
          if (pixel_out !== want) begin
            $error("pixel_out mismatch: expected %06h, actual %06h", want, pixel_out);
            err_cnt++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    logic [2:0]  mode;
    int unsigned gap;
    int unsigned sel;

    // Directed: channel extremes in the five named modes, sepia saturation, posterize
    // level boundaries and the unused mode codes.
    add_step(STEP_MODE, rcf_pkg::MODE_ORIGINAL);
    add_pixel(24'h000000, 0);
    add_pixel(24'hFFFFFF, 0);
    add_pixel(24'h123456, 1);
    add_step(STEP_MODE, rcf_pkg::MODE_GRAY);
    add_pixel(24'hFFFFFF, 0);
    add_pixel(24'h000000, 0);
    add_pixel(24'h010203, 2);
    add_step(STEP_MODE, rcf_pkg::MODE_SEPIA);
    add_pixel(24'hFFFFFF, 0);
    add_pixel(24'h202020, 0);
    add_pixel(24'h646464, 0);
    add_pixel(24'hFF0000, 3);
    add_step(STEP_MODE, rcf_pkg::MODE_INVERT);
    add_pixel(24'h00FF5A, 0);
    add_pixel(24'hFFFFFF, 0);
    add_step(STEP_MODE, rcf_pkg::MODE_POSTERIZE);
    add_pixel(24'h3F40BF, 0);
    add_pixel(24'hC0FF00, 1);
    add_step(STEP_MODE, MODE_RSVD5);
    add_pixel(24'hABCDEF, 0);
    add_step(STEP_MODE, MODE_RSVD6);
    add_pixel(24'h0F0F0F, 0);
    add_step(STEP_MODE, MODE_RSVD7);
    add_pixel(24'hFFFFFF, 0);

    // Random phases: every mode code, back-to-back input in every third phase, gappy input in the rest.
    for (int p = 0; p < 16; p++) begin
      mode = (p < 8) ? p[2:0] : 3'($urandom_range(0, 7));
      add_step(STEP_MODE, mode);
      for (int i = 0; i < 56; i++) begin
        gap = (p % 3 == 0) ? 0 : $urandom_range(0, 6);
        sel = $urandom_range(0, 3);
        if (sel == 0) add_pixel({pick_channel(), pick_channel(), pick_channel()}, gap);
        else add_pixel(24'($urandom), gap);
        if (p == 9 && i == 28) add_step(STEP_DRAIN, '0);
      end
    end

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    while (stim_q.size() != 0 || in_valid || filtered_q.size() != 0) @(posedge clk);
    repeat (PIPE_DEPTH + 5) @(posedge clk);

    if (err_cnt == 0 && filtered_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

### files.f
rtl/rcf_pkg.sv
rtl/rcf_sum_stage.sv
rtl/rcf_out_stage.sv
rtl/rgb_color_filter_unit.sv
tb/rgb_color_filter_unit_tb.sv
